[sv/button_debounce_press_queue_core_macros.svh]
// Assertion macros shared by the debounce press queue RTL.
`ifndef BUTTON_DEBOUNCE_PRESS_QUEUE_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_QUEUE_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define BDPQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdpq assertion failed");

// next-cycle implication
`define BDPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdpq assertion failed");

`endif

[sv/bdpq_pkg.sv]
// Types and constants for the debounce press queue.
package bdpq_pkg;

    localparam int TIME_W   = 32;
    localparam int LEVEL_W  = 4;
    localparam int KEY_W    = 3;
    localparam int QCOUNT_W = 5;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 32;
    localparam int IN_DW    = 40;
    localparam int OUT_DW   = 16;

    localparam logic [CFG_AW-1:0] REG_POLARITY = 2'd0;
    localparam logic [CFG_AW-1:0] REG_DEBOUNCE = 2'd1;
    localparam logic [CFG_AW-1:0] REG_SHORT    = 2'd2;
    localparam logic [CFG_AW-1:0] REG_LONG     = 2'd3;

    localparam logic [LEVEL_W-1:0] POLARITY_RST = 4'd15;
    localparam logic [TIME_W-1:0]  DEBOUNCE_RST = 32'd10000;
    localparam logic [TIME_W-1:0]  SHORT_RST    = 32'd50000;
    localparam logic [TIME_W-1:0]  LONG_RST     = 32'd1000000;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_DEBOUNCE = 4'b0010,
        ST_PRESSED  = 4'b0100,
        ST_WAITING  = 4'b1000
    } press_state_t;

    typedef struct packed {
        press_state_t       state;
        logic [TIME_W-1:0]  start;
    } btn_entry_t;

endpackage

[sv/bdpq_ram.sv]
// Generic simple dual-port RAM with registered read.
module bdpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/button_debounce_press_queue_core.sv]
// Pipeline: 2 stages, the stage 1 registers and then the output registers.
// Throughput: one transaction per cycle when the output is not stalled, set by the
// read-modify-write of the button state memory (with write forwarding) and the key queue memory.
// Reset: asynchronous; clears control state, restores register defaults, marks every
// button entry invalid so it reads as idle with start zero; no clearing pass.
`include "button_debounce_press_queue_core_macros.svh"

module button_debounce_press_queue_core #(
    parameter int NUM_BUTTONS = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [3:0] raw_levels, [35:4] now_us, [39:36] zero
    input  logic [bdpq_pkg::IN_DW-1:0]     s_axis_tdata,
    // [0] op
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [2:0] key_code, [3] dropped, [8:4] queue_count, [15:9] zero
    output logic [bdpq_pkg::OUT_DW-1:0]    m_axis_tdata,
    // [0] key_valid
    output logic                           m_axis_tuser,
    input  logic                           cfg_we,
    input  logic [bdpq_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [bdpq_pkg::CFG_DW-1:0]    cfg_wdata
);

    import bdpq_pkg::*;

    localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = $bits(btn_entry_t);

    // configuration
    logic [LEVEL_W-1:0] polarity_reg;
    logic [TIME_W-1:0]  debounce_reg;
    logic [TIME_W-1:0]  short_reg;
    logic [TIME_W-1:0]  long_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polarity_reg <= POLARITY_RST;
            debounce_reg <= DEBOUNCE_RST;
            short_reg    <= SHORT_RST;
            long_reg     <= LONG_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_POLARITY: polarity_reg <= cfg_wdata[LEVEL_W-1:0];
                REG_DEBOUNCE: debounce_reg <= cfg_wdata;
                REG_SHORT:    short_reg    <= cfg_wdata;
                REG_LONG:     long_reg     <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // handshake
    logic in_fire;
    logic s1_fire;
    logic s1_valid_reg;
    logic out_valid_reg;

    assign s1_fire       = s1_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~s1_valid_reg | s1_fire;
    assign in_fire       = s_axis_tvalid & s_axis_tready;

    // stage 1 registers
    logic               s1_op_reg;
    logic [LEVEL_W-1:0] s1_levels_reg;
    logic [TIME_W-1:0]  s1_now_reg;
    logic [BW-1:0]      s1_idx_reg;
    logic               s1_hit_reg;
    logic               s1_btn_fwd_reg;
    btn_entry_t         s1_btn_fwd_data_reg;
    logic               s1_key_fwd_reg;
    logic [KEY_W-1:0]   s1_key_fwd_data_reg;

    // state registers
    logic [BW-1:0]          scan_idx_reg;
    logic [BW-1:0]          scan_idx_next;
    logic [NUM_BUTTONS-1:0] btn_valid_reg;
    logic [QW-1:0]          rd_ptr_reg;
    logic [QW-1:0]          rd_ptr_next;
    logic [QW-1:0]          wr_ptr_reg;
    logic [QW-1:0]          wr_ptr_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;

    // memories
    logic             btn_we;
    btn_entry_t       btn_wdata;
    logic [EW-1:0]    btn_rdata;
    logic             key_we;
    logic [KEY_W-1:0] key_wdata;
    logic [KEY_W-1:0] key_rdata;

    bdpq_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_BUTTONS)
    ) u_btn_ram (
        .clk   (clk),
        .we    (btn_we),
        .waddr (s1_idx_reg),
        .wdata (btn_wdata),
        .re    (in_fire),
        .raddr (scan_idx_reg),
        .rdata (btn_rdata)
    );

    bdpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (wr_ptr_reg),
        .wdata (key_wdata),
        .re    (in_fire),
        .raddr (rd_ptr_next),
        .rdata (key_rdata)
    );

    // pressed flag per button; buttons past the input width read level 0, polarity 0
    logic [NUM_BUTTONS-1:0] down_vec;

    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_down
        if (i < LEVEL_W)
        begin : g_pin
            assign down_vec[i] = s1_levels_reg[i] ~^ polarity_reg[i];
        end
        else
        begin : g_none
            assign down_vec[i] = 1'b1;
        end
    end

    // stage 1 logic
    btn_entry_t        entry;
    logic [TIME_W-1:0] held;
    logic              down;
    logic              found;
    logic              is_long;
    logic              full;
    logic [KEY_W-1:0]  res_code;
    logic              res_valid;
    logic              res_drop;

    always_comb
    begin
        if (s1_btn_fwd_reg)
        begin
            entry = s1_btn_fwd_data_reg;
        end
        else if (s1_hit_reg)
        begin
            entry = btn_entry_t'(btn_rdata);
        end
        else
        begin
            entry.state = ST_IDLE;
            entry.start = '0;
        end

        held      = s1_now_reg - entry.start;
        down      = down_vec[s1_idx_reg];
        found     = 1'b0;
        is_long   = 1'b0;
        btn_wdata = entry;

        case (entry.state)
            ST_IDLE:
            begin
                if (down)
                begin
                    btn_wdata.state = ST_DEBOUNCE;
                    btn_wdata.start = s1_now_reg;
                end
            end
            ST_DEBOUNCE:
            begin
                if (!down)
                begin
                    btn_wdata.state = ST_IDLE;
                end
                else if (held > debounce_reg)
                begin
                    btn_wdata.state = ST_PRESSED;
                end
            end
            ST_PRESSED:
            begin
                if (down)
                begin
                    if (held > long_reg)
                    begin
                        found           = 1'b1;
                        is_long         = 1'b1;
                        btn_wdata.state = ST_WAITING;
                    end
                end
                else
                begin
                    found           = held > short_reg;
                    btn_wdata.state = ST_IDLE;
                end
            end
            ST_WAITING:
            begin
                if (!down)
                begin
                    btn_wdata.state = ST_IDLE;
                end
            end
            default:
            begin
                btn_wdata.state = ST_IDLE;
            end
        endcase

        full      = (count_reg == CW'(QUEUE_DEPTH));
        key_wdata = KEY_W'({s1_idx_reg, is_long});

        res_valid   = 1'b0;
        res_code    = '0;
        res_drop    = 1'b0;
        btn_we      = 1'b0;
        key_we      = 1'b0;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;

        if (s1_op_reg == OP_SCAN)
        begin
            btn_we = s1_fire;
            if (found)
            begin
                res_valid = 1'b1;
                res_code  = key_wdata;
                res_drop  = full;
                if (!full)
                begin
                    key_we = s1_fire;
                end
            end
        end
        else if (count_reg != '0)
        begin
            res_valid = 1'b1;
            res_code  = s1_key_fwd_reg ? s1_key_fwd_data_reg : key_rdata;
        end

        if (s1_fire)
        begin
            if (key_we)
            begin
                wr_ptr_next = (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
                count_next  = count_reg + 1'b1;
            end
            else if (s1_op_reg == OP_READ && res_valid)
            begin
                rd_ptr_next = (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
                count_next  = count_reg - 1'b1;
            end
        end

        scan_idx_next = scan_idx_reg;
        if (in_fire && s_axis_tuser == OP_SCAN)
        begin
            scan_idx_next = (scan_idx_reg == BW'(NUM_BUTTONS - 1)) ? '0
                                                                   : scan_idx_reg + 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
            btn_valid_reg <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            out_valid_reg <= s1_fire | (out_valid_reg & ~m_axis_tready);
            scan_idx_reg  <= scan_idx_next;
            if (btn_we)
            begin
                btn_valid_reg[s1_idx_reg] <= 1'b1;
            end
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload
    logic [KEY_W-1:0]    out_code_reg;
    logic                out_key_valid_reg;
    logic                out_drop_reg;
    logic [QCOUNT_W-1:0] out_count_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg           <= s_axis_tuser;
            s1_levels_reg       <= s_axis_tdata[LEVEL_W-1:0];
            s1_now_reg          <= s_axis_tdata[LEVEL_W +: TIME_W];
            s1_idx_reg          <= scan_idx_reg;
            s1_hit_reg          <= btn_valid_reg[scan_idx_reg];
            s1_btn_fwd_reg      <= btn_we && (s1_idx_reg == scan_idx_reg);
            s1_btn_fwd_data_reg <= btn_wdata;
            s1_key_fwd_reg      <= key_we && (wr_ptr_reg == rd_ptr_next);
            s1_key_fwd_data_reg <= key_wdata;
        end
        if (s1_fire)
        begin
            out_key_valid_reg <= res_valid;
            out_code_reg      <= res_code;
            out_drop_reg      <= res_drop;
            out_count_reg     <= QCOUNT_W'(count_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_key_valid_reg;
    assign m_axis_tdata  = {{(OUT_DW - QCOUNT_W - 1 - KEY_W){1'b0}},
                            out_count_reg, out_drop_reg, out_code_reg};

    `BDPQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    `BDPQ_ASSERT_IMP(a_empty_ptrs, count_reg == '0, rd_ptr_reg == wr_ptr_reg)
    `BDPQ_ASSERT_IMP(a_drop_full, s1_fire && res_drop, full && !key_we)
    `BDPQ_ASSERT_NEXT(a_empty_read, s1_fire && s1_op_reg == OP_READ && count_reg == '0,
                      out_valid_reg && !out_key_valid_reg)

endmodule
